FILE: design/ddo_pkg.sv
package ddo_pkg;

	localparam int CORDIC_STEPS = 24;

	localparam logic [1:0] CFG_MATCH_ID      = 2'd0;
	localparam logic [1:0] CFG_SPEED_PER_RPM = 2'd1;
	localparam logic [1:0] CFG_INV_TREAD     = 2'd2;

	localparam logic [19:0] DT_MAX_US = 20'hFFFFF;
	localparam logic [23:0] YAW_K     = 24'd11199533;
	localparam logic [19:0] DIV_K     = 20'd1000000;
	localparam logic [19:0] HALF_K    = 20'd500000;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	// 2^52 / 10^6 rounded down, quotient estimate from the top 32 bits
	localparam logic [32:0] RECIP_K   = 33'd4503599627;
	localparam logic [21:0] DIV_K2    = 22'd2000000;
	localparam logic [21:0] DIV_K3    = 22'd3000000;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef struct packed {
		logic [28:0] can_id;
		logic [7:0]  left_rpm;
		logic [7:0]  right_rpm;
		logic [47:0] timestamp_us;
	} ddo_in_t;

	typedef struct packed {
		logic signed [39:0] pos_x;
		logic signed [39:0] pos_y;
		logic [31:0]        heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] yaw_rate;
	} ddo_out_t;

	typedef struct packed {
		logic [7:0]  left_rpm;
		logic [7:0]  right_rpm;
		logic [47:0] timestamp_us;
	} ddo_item_t;

	typedef struct packed {
		logic      valid;
		ddo_item_t item;
	} ddo_head_t;

	typedef struct packed {
		logic [31:0] speed_per_rpm;
		logic [31:0] inv_tread;
	} ddo_cfg_t;

endpackage

FILE: design/ddo_front.sv
module ddo_front import ddo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ddo_in_t     in_data,
	input  logic [28:0] match_id,
	output ddo_head_t   head,
	input  logic        pop
);

	ddo_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	assign in_ready = (count_q != 2'd2);
	// foreign identifiers are taken and dropped here
	assign push   = in_valid && in_ready && (in_data.can_id == match_id);
	assign do_pop = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{left_rpm: in_data.left_rpm, right_rpm: in_data.right_rpm,
				timestamp_us: in_data.timestamp_us};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !do_pop) count_q <= count_q + 2'd1;
			else if (!push && do_pop) count_q <= count_q - 2'd1;
		end
	end

endmodule

FILE: design/ddo_back.sv
module ddo_back import ddo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ddo_head_t head,
	output logic      pop,
	input  ddo_cfg_t  cfg,
	output logic      out_valid,
	input  logic      out_ready,
	output ddo_out_t  out_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_MULV, ST_MEAN, ST_MHI, ST_MLO, ST_WMAG, ST_MP, ST_MPH, ST_MPL,
		ST_YAW, ST_CINIT, ST_CORD, ST_VMX, ST_VMY, ST_VSAT, ST_PMUL, ST_QEST, ST_QREM,
		ST_QFIX, ST_ACC
	} state_t;

	localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);

	state_t state_q;
	logic [7:0]  rl_q, rr_q;
	logic [47:0] ts_q;
	logic [39:0] vl_q, vr_q;
	logic [30:0] mean_q;
	logic [39:0] d_q;
	logic        wneg_q;
	logic [19:0] dt_q;
	logic [51:0] hi_q, lo_q;
	logic [30:0] wmag_q;
	logic [50:0] p_q;
	logic [48:0] mh_q;
	logic [49:0] ml_q;
	logic        seen_q;
	logic [47:0] last_q;
	logic [31:0] yaw_q;
	logic signed [47:0] xacc_q, yacc_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0]  it_q;
	logic signed [65:0] pr_q;
	logic signed [31:0] vx_q, vy_q;
	logic [51:0] nx_q, ny_q;
	logic [21:0] rmx_q, rmy_q;
	logic [31:0] qx_q, qy_q;
	logic        out_valid_q;
	ddo_out_t    out_q;

	logic [41:0] vsum;
	logic [30:0] mean_n;
	logic [39:0] d_n;
	logic [47:0] dtr;
	logic [19:0] dt_n;
	logic [33:0] lo_r;
	logic [52:0] wsum;
	logic [30:0] wmag_n;
	logic [24:0] mlr;
	logic [49:0] msum;
	logic [31:0] dyaw;
	logic        flip;
	logic [31:0] zr;
	logic signed [33:0] xs, ys, at;
	logic signed [35:0] vt;
	logic signed [31:0] vsat;
	logic [31:0] magx, magy;
	logic [51:0] nx, ny;
	logic [64:0] pex, pey;
	logic [51:0] qkx, qky;
	logic [51:0] dfx, dfy;
	logic [31:0] adjx, adjy;
	logic signed [49:0] sx, sy;
	logic signed [47:0] xacc_n, yacc_n;
	logic        out_free;

	always_comb begin
		vsum   = {2'b0, vl_q} + {2'b0, vr_q} + 42'd256;
		mean_n = (vsum[41:40] != 2'b00) ? 31'h7FFFFFFF : vsum[39:9];
		d_n    = (vr_q < vl_q) ? vl_q - vr_q : vr_q - vl_q;
		dtr    = ts_q - last_q;
		dt_n   = !seen_q ? 20'd0 : ((dtr[47:20] != 28'd0) ? DT_MAX_US : dtr[19:0]);

		// rounding bit lands at 2^33 of the low partial product
		lo_r   = 34'(({2'b0, lo_q} + (54'd1 << 33)) >> 20);
		wsum   = {1'b0, hi_q} + {19'b0, lo_r};
		wmag_n = (wsum[52:45] != 8'd0) ? 31'h7FFFFFFF : wsum[44:14];

		mlr    = 25'(({1'b0, ml_q} + (51'd1 << 35)) >> 26);
		msum   = {1'b0, mh_q} + {25'b0, mlr};
		dyaw   = wneg_q ? (32'd0 - msum[41:10]) : msum[41:10];

		flip   = (yaw_q[31:30] == 2'b01) || (yaw_q[31:30] == 2'b10);
		zr     = flip ? (yaw_q - 32'h80000000) : yaw_q;

		xs     = cx_q >>> it_q;
		ys     = cy_q >>> it_q;
		at     = $signed({2'b0, ATAN_TAB[it_q]});

		vt     = 36'((pr_q + 66'sd536870912) >>> 30);
		if ((vt[35:31] != 5'b00000) && (vt[35:31] != 5'b11111))
			vsat = vt[35] ? 32'sh80000000 : 32'sh7FFFFFFF;
		else
			vsat = vt[31:0];

		magx   = vx_q[31] ? (32'd0 - vx_q) : vx_q;
		magy   = vy_q[31] ? (32'd0 - vy_q) : vy_q;
		nx     = magx * dt_q + {32'd0, HALF_K};
		ny     = magy * dt_q + {32'd0, HALF_K};

		// quotient estimate from the top word, at most two short of the true value
		pex    = nx_q[51:20] * RECIP_K;
		pey    = ny_q[51:20] * RECIP_K;
		qkx    = qx_q * DIV_K;
		qky    = qy_q * DIV_K;
		dfx    = nx_q - qkx;
		dfy    = ny_q - qky;
		adjx   = (rmx_q >= DIV_K3) ? 32'd3 : (rmx_q >= DIV_K2) ? 32'd2 :
			(rmx_q >= {2'b0, DIV_K}) ? 32'd1 : 32'd0;
		adjy   = (rmy_q >= DIV_K3) ? 32'd3 : (rmy_q >= DIV_K2) ? 32'd2 :
			(rmy_q >= {2'b0, DIV_K}) ? 32'd1 : 32'd0;

		sx     = vx_q[31] ? ({{2{xacc_q[47]}}, xacc_q} - $signed({18'd0, qx_q}))
			: ({{2{xacc_q[47]}}, xacc_q} + $signed({18'd0, qx_q}));
		sy     = vy_q[31] ? ({{2{yacc_q[47]}}, yacc_q} - $signed({18'd0, qy_q}))
			: ({{2{yacc_q[47]}}, yacc_q} + $signed({18'd0, qy_q}));
		if ((sx[49:47] != 3'b000) && (sx[49:47] != 3'b111))
			xacc_n = sx[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			xacc_n = sx[47:0];
		if ((sy[49:47] != 3'b000) && (sy[49:47] != 3'b111))
			yacc_n = sy[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			yacc_n = sy[47:0];

		out_free = !out_valid_q || out_ready;
	end

	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= 1'b0;
			last_q      <= '0;
			yaw_q       <= '0;
			xacc_q      <= '0;
			yacc_q      <= '0;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_ACC) && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						rl_q    <= head.item.left_rpm;
						rr_q    <= head.item.right_rpm;
						ts_q    <= head.item.timestamp_us;
						state_q <= ST_MULV;
					end
				end
				ST_MULV: begin
					vl_q    <= rl_q * cfg.speed_per_rpm;
					vr_q    <= rr_q * cfg.speed_per_rpm;
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					mean_q  <= mean_n;
					d_q     <= d_n;
					wneg_q  <= vr_q < vl_q;
					dt_q    <= dt_n;
					seen_q  <= 1'b1;
					last_q  <= ts_q;
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					hi_q    <= d_q[39:20] * cfg.inv_tread;
					state_q <= ST_MLO;
				end
				ST_MLO: begin
					lo_q    <= d_q[19:0] * cfg.inv_tread;
					state_q <= ST_WMAG;
				end
				ST_WMAG: begin
					wmag_q  <= wmag_n;
					state_q <= ST_MP;
				end
				ST_MP: begin
					p_q     <= wmag_q * dt_q;
					state_q <= ST_MPH;
				end
				ST_MPH: begin
					mh_q    <= p_q[50:26] * YAW_K;
					state_q <= ST_MPL;
				end
				ST_MPL: begin
					ml_q    <= p_q[25:0] * YAW_K;
					state_q <= ST_YAW;
				end
				ST_YAW: begin
					yaw_q   <= yaw_q + dyaw;
					state_q <= ST_CINIT;
				end
				ST_CINIT: begin
					cx_q    <= flip ? -CORDIC_X0 : CORDIC_X0;
					cy_q    <= '0;
					cz_q    <= {{2{zr[31]}}, zr};
					it_q    <= '0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + at;
					end
					it_q <= it_q + 5'd1;
					if (it_q == CORD_LAST) state_q <= ST_VMX;
				end
				ST_VMX: begin
					pr_q    <= $signed({1'b0, mean_q}) * cx_q;
					state_q <= ST_VMY;
				end
				ST_VMY: begin
					vx_q    <= vsat;
					pr_q    <= $signed({1'b0, mean_q}) * cy_q;
					state_q <= ST_VSAT;
				end
				ST_VSAT: begin
					vy_q    <= vsat;
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					nx_q    <= nx;
					ny_q    <= ny;
					state_q <= ST_QEST;
				end
				ST_QEST: begin
					qx_q    <= pex[63:32];
					qy_q    <= pey[63:32];
					state_q <= ST_QREM;
				end
				ST_QREM: begin
					rmx_q   <= dfx[21:0];
					rmy_q   <= dfy[21:0];
					state_q <= ST_QFIX;
				end
				ST_QFIX: begin
					qx_q    <= qx_q + adjx;
					qy_q    <= qy_q + adjy;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (out_free) begin
						xacc_q         <= xacc_n;
						yacc_q         <= yacc_n;
						out_q.pos_x    <= xacc_n[47:8];
						out_q.pos_y    <= yacc_n[47:8];
						out_q.heading  <= yaw_q;
						out_q.vel_x    <= vx_q;
						out_q.vel_y    <= vy_q;
						out_q.yaw_rate <= wneg_q ? (32'sd0 - $signed({1'b0, wmag_q}))
							: $signed({1'b0, wmag_q});
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/diff_drive_wheel_odometry.sv
// channel   direction  handshake                    payload
// in        to block   in_valid / in_ready          ddo_in_t  (frame id, rpm, stamp)
// out       from block out_valid / out_ready        ddo_out_t (pose, velocity, rate)
// cfg       to block   cfg_we, cfg_index, cfg_data  match_id, speed_per_rpm, inv_tread
//
// in the back sequencer the CORDIC iterations dominate the work on a matching frame;
// the divide by one million is a reciprocal multiply followed by a remainder
// correction, through states ST_QEST, ST_QREM and ST_QFIX
// frames with a foreign identifier are accepted and give no result
// reset is asynchronous and clears pose, heading, time base and the frame queue
// a two entry queue lets frames arrive while the sequencer works; a held result stalls
// the sequencer only at its last step
module diff_drive_wheel_odometry import ddo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ddo_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ddo_out_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [28:0] match_id_q;
	ddo_cfg_t    cfg_q;
	ddo_head_t   head;
	logic        pop;

	// configuration registers, writes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_id_q <= '0;
			cfg_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MATCH_ID:      match_id_q          <= cfg_data[28:0];
				CFG_SPEED_PER_RPM: cfg_q.speed_per_rpm <= cfg_data;
				CFG_INV_TREAD:     cfg_q.inv_tread     <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: identifier filter and frame queue
	ddo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.match_id (match_id_q),
		.head     (head),
		.pop      (pop)
	);

	// back: speed, rate, heading, CORDIC rotation and position integration
	ddo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: design/ddo_checker.sv
module ddo_checker import ddo_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input ddo_out_t out_data
);

	logic               seen_in_q;
	logic               have_prev_q;
	logic signed [39:0] prev_x_q, prev_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q   <= 1'b0;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else begin
			if (in_valid && in_ready) seen_in_q <= 1'b1;
			if (out_valid && out_ready) begin
				have_prev_q <= 1'b1;
				prev_x_q    <= out_data.pos_x;
				prev_y_q    <= out_data.pos_y;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result beat changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_in_q)
		else $error("result beat with no frame taken");

	a_still_pose: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q && (out_data.vel_x == 32'sd0) && (out_data.vel_y == 32'sd0)
		|-> (out_data.pos_x == prev_x_q) && (out_data.pos_y == prev_y_q))
		else $error("position moved with zero velocity");

endmodule

bind diff_drive_wheel_odometry ddo_checker u_ddo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: tb/sv/tb.sv
module tb;
	import ddo_pkg::*;

	localparam int LIMIT_CYCLES  = 2000000;
	localparam int SETTLE_CYCLES = 200;   // above the back sequencer's run plus queue drain

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	ddo_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	ddo_out_t    out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	diff_drive_wheel_odometry DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// frames waiting to be driven, and poses waiting to come out
	ddo_in_t  frame_q[$];
	ddo_out_t pose_q[$];
	int       fail_count = 0;
	int       cycle_count = 0;
	bit       no_idle = 0;

	// odometry model: configuration copy and integrator state
	logic [28:0] m_match;
	logic [31:0] m_speed;
	logic [31:0] m_inv_tread;
	bit          m_seen_first;
	logic [47:0] m_last_stamp;
	logic [31:0] m_heading;
	longint      m_x_acc;
	longint      m_y_acc;

	initial clk = 0;
	always #6 clk = ~clk;

	// position integration, rounded half away from zero, saturated to 48 bits signed
	function automatic longint integrate(input longint acc, input longint vel,
		input logic [63:0] dt);
		logic [63:0] mag;
		logic [63:0] q;
		longint r;
		mag = (vel < 0) ? 64'(-vel) : 64'(vel);
		q = (mag * dt + 64'(HALF_K)) / 64'(DIV_K);
		r = (vel < 0) ? acc - longint'(q) : acc + longint'(q);
		if (r > 64'sh7FFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF;
		if (r < -64'sh8000_0000_0000) r = -64'sh8000_0000_0000;
		return r;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// advance the model by one frame; returns 0 for a foreign identifier
	function automatic bit odo_advance(input ddo_in_t f, output ddo_out_t pose);
		logic [63:0] vl, vr, mean, d, hi, lo, wmag, dt, p, ph, pl, m;
		logic [47:0] dstamp;
		logic [31:0] dyaw, zr;
		logic [1:0]  quad;
		bit          wneg;
		longint      x, y, z, t, xs, ys, vx, vy, rate;
		pose = '0;
		if (f.can_id != m_match) return 0;
		vl = 64'(f.left_rpm) * 64'(m_speed);
		vr = 64'(f.right_rpm) * 64'(m_speed);
		mean = (vl + vr + 64'd256) >> 9;
		if (mean > 64'd2147483647) mean = 64'd2147483647;

		wneg = vr < vl;
		d = wneg ? vl - vr : vr - vl;
		hi = (d >> 20) * 64'(m_inv_tread);
		lo = (d & 64'hFFFFF) * 64'(m_inv_tread);
		wmag = (hi + ((lo + (64'd1 << 33)) >> 20)) >> 14;
		if (wmag > 64'd2147483647) wmag = 64'd2147483647;
		rate = wneg ? -longint'(wmag) : longint'(wmag);

		// first frame has no time base; a backwards stamp wraps and then saturates
		if (m_seen_first) begin
			dstamp = f.timestamp_us - m_last_stamp;
			dt = 64'(dstamp);
			if (dt > 64'(DT_MAX_US)) dt = 64'(DT_MAX_US);
		end else begin
			dt = 0;
		end
		m_seen_first = 1;
		m_last_stamp = f.timestamp_us;

		p = wmag * dt;
		ph = p >> 26;
		pl = p & ((64'd1 << 26) - 1);
		m = (ph * 64'(YAW_K) + ((pl * 64'(YAW_K) + (64'd1 << 35)) >> 26)) >> 10;
		dyaw = m[31:0];
		if (wneg) dyaw = -dyaw;
		m_heading = m_heading + dyaw;

		// rotation mode cordic, second and third quadrants folded by half a turn
		x = longint'(CORDIC_X0);
		y = 0;
		quad = m_heading[31:30];
		zr = m_heading;
		if (quad == 2'b01 || quad == 2'b10) begin
			x = -x;
			zr = m_heading - 32'h8000_0000;
		end
		z = longint'($signed(zr));
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				t = x - ys; y = y + xs; x = t;
				z -= longint'(ATAN_TAB[i]);
			end else begin
				t = x + ys; y = y - xs; x = t;
				z += longint'(ATAN_TAB[i]);
			end
		end

		vx = clip32((longint'(mean) * x + (64'sd1 <<< 29)) >>> 30);
		vy = clip32((longint'(mean) * y + (64'sd1 <<< 29)) >>> 30);
		m_x_acc = integrate(m_x_acc, vx, dt);
		m_y_acc = integrate(m_y_acc, vy, dt);

		pose.pos_x    = 40'(m_x_acc >>> 8);
		pose.pos_y    = 40'(m_y_acc >>> 8);
		pose.heading  = m_heading;
		pose.vel_x    = 32'(vx);
		pose.vel_y    = 32'(vy);
		pose.yaw_rate = 32'(rate);
		return 1;
	endfunction

	// model follows register writes and accepted frames at the same edge as the block
	always @(posedge clk or negedge arst_n) begin
		ddo_out_t pose;
		if (!arst_n) begin
			m_match <= '0;
			m_speed <= '0;
			m_inv_tread <= '0;
			m_seen_first = 0;
			m_last_stamp = '0;
			m_heading = '0;
			m_x_acc = 0;
			m_y_acc = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MATCH_ID:      m_match <= cfg_data[28:0];
					CFG_SPEED_PER_RPM: m_speed <= cfg_data;
					CFG_INV_TREAD:     m_inv_tread <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (odo_advance(in_data, pose)) pose_q.push_back(pose);
			end
		end
	end

	// frame driver: pops a beat from the queue, holds it until accepted
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic    nxt_valid;
		ddo_in_t nxt_data;
		int      r;
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			send_gap = 0;
		end else begin
			nxt_valid = in_valid;
			nxt_data = in_data;
			if (!in_valid || in_ready) begin
				nxt_valid = 0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (frame_q.size() > 0) begin
					nxt_valid = 1;
					nxt_data = frame_q.pop_front();
					r = $urandom_range(0, 99);
					// mostly back to back or short gaps, now and then a long one
					if (no_idle || r < 55) send_gap = 0;
					else if (r < 90) send_gap = $urandom_range(1, 4);
					else send_gap = $urandom_range(10, 120);
				end
			end
			in_valid <= nxt_valid;
			in_data <= nxt_data;
		end
	end

	// pose sink: random back-pressure, a mix of short and long stalls
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			out_ready <= 0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else begin
			r = $urandom_range(0, 99);
			if (no_idle || r < 70) stall_left = 0;
			else if (r < 95) stall_left = $urandom_range(1, 3);
			else stall_left = $urandom_range(10, 100);
			out_ready <= (stall_left == 0);
		end
	end

	task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
		fail_count++;
	endtask

	// compare each pose beat with the oldest prediction
	always @(posedge clk) begin
		ddo_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pose_q.size() == 0) begin
				$display("%0t: unexpected pose beat %h", $time, out_data);
				fail_count++;
			end else begin
				want = pose_q.pop_front();
				if (want.pos_x !== out_data.pos_x)
					report("pos_x", 64'(want.pos_x), 64'(out_data.pos_x));
				if (want.pos_y !== out_data.pos_y)
					report("pos_y", 64'(want.pos_y), 64'(out_data.pos_y));
				if (want.heading !== out_data.heading)
					report("heading", 64'(want.heading), 64'(out_data.heading));
				if (want.vel_x !== out_data.vel_x)
					report("vel_x", 64'(want.vel_x), 64'(out_data.vel_x));
				if (want.vel_y !== out_data.vel_y)
					report("vel_y", 64'(want.vel_y), 64'(out_data.vel_y));
				if (want.yaw_rate !== out_data.yaw_rate)
					report("yaw_rate", 64'(want.yaw_rate), 64'(out_data.yaw_rate));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** diff_drive_wheel_odometry: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// wait until every frame is driven and every predicted pose has come out, then let the block settle
	task automatic drain();
		while (frame_q.size() > 0 || in_valid || pose_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_frame(input logic [28:0] id, input logic [7:0] lrpm,
		input logic [7:0] rrpm, input logic [47:0] stamp);
		ddo_in_t f;
		f.can_id = id;
		f.left_rpm = lrpm;
		f.right_rpm = rrpm;
		f.timestamp_us = stamp;
		frame_q.push_back(f);
	endtask

	logic [47:0] stamp_cursor = '0;

	// random frames: mostly matching with a steady clock, some foreign ids and time jumps
	task automatic random_frames(input int count);
		logic [28:0] id;
		logic [7:0]  lrpm, rrpm;
		int          r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 80) id = m_match;
			else if (r < 90) id = m_match ^ (29'd1 << $urandom_range(0, 28));
			else id = 29'($urandom);
			r = $urandom_range(0, 99);
			lrpm = 8'($urandom);
			rrpm = 8'($urandom);
			if (r < 10) rrpm = lrpm;
			else if (r < 15) lrpm = 8'hFF;
			else if (r < 20) rrpm = 8'h00;
			r = $urandom_range(0, 99);
			if (r < 75) stamp_cursor += 48'($urandom_range(1, 30000));
			else if (r < 85) stamp_cursor += 48'($urandom_range(1048000, 5000000));
			else if (r < 90) stamp_cursor -= 48'($urandom_range(1, 100000));
			else stamp_cursor = {16'($urandom), 32'($urandom)};
			push_frame(id, lrpm, rrpm, stamp_cursor);
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = CFG_MATCH_ID;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// registers at reset: id zero matches, all speeds and rates zero
		push_frame(29'd0, 8'd255, 8'd0, 48'd1000);
		push_frame(29'd5, 8'd10, 8'd20, 48'd2000);
		push_frame(29'd0, 8'd0, 8'd255, 48'd5000);
		drain();

		// saturating gains, extremes of every field
		write_reg(CFG_MATCH_ID, 32'h01AB_CDEF);
		write_reg(CFG_SPEED_PER_RPM, 32'hFFFF_FFFF);
		write_reg(CFG_INV_TREAD, 32'hFFFF_FFFF);
		drain();
		push_frame(29'h01AB_CDEF, 8'd0, 8'd0, 48'hFFFF_FFFF_FFFF);     // first frame
		push_frame(29'h01AB_CDEF, 8'd255, 8'd255, 48'd100);             // wrap forward
		push_frame(29'h01AB_CDEF, 8'd255, 8'd0, 48'd50);                // time going back
		push_frame(29'h1FFF_FFFF, 8'd1, 8'd1, 48'd60);                  // foreign id
		push_frame(29'h01AB_CDEF, 8'd0, 8'd255, 48'd9_000_000);         // long gap
		push_frame(29'h01AB_CDEF, 8'd1, 8'd0, 48'd9_000_001);
		push_frame(29'h01AB_CDEF, 8'd0, 8'd1, 48'd9_500_000);
		drain();

		// realistic gains: speed per rpm near 5 mm/s, tread near half a metre
		write_reg(CFG_SPEED_PER_RPM, 32'd22_500_000);
		write_reg(CFG_INV_TREAD, 32'd33_554_432);
		drain();
		push_frame(29'h01AB_CDEF, 8'd128, 8'd0, 48'd10_000_000);
		push_frame(29'h01AB_CDEF, 8'd0, 8'd128, 48'd10_200_000);
		push_frame(29'h01AB_CDEF, 8'd200, 8'd200, 48'd11_248_575);
		push_frame(29'h01AB_CDEF, 8'd255, 8'd100, 48'd12_000_000);
		stamp_cursor = 48'd12_000_000;
		random_frames(130);
		drain();

		// all-ones id, zero speed, random rate gain
		write_reg(CFG_MATCH_ID, 32'hFFFF_FFFF);
		write_reg(CFG_SPEED_PER_RPM, 32'd0);
		write_reg(CFG_INV_TREAD, $urandom);
		drain();
		random_frames(60);
		drain();

		// random gains, zero rate gain
		write_reg(CFG_MATCH_ID, $urandom);
		write_reg(CFG_SPEED_PER_RPM, $urandom);
		write_reg(CFG_INV_TREAD, 32'd0);
		drain();
		random_frames(60);
		drain();

		// fast turning so the heading visits every quadrant; a stretch without idling
		write_reg(CFG_MATCH_ID, 32'd0);
		write_reg(CFG_SPEED_PER_RPM, 32'd90_000_000);
		write_reg(CFG_INV_TREAD, 32'd400_000_000);
		drain();
		no_idle = 1;
		random_frames(100);
		drain();
		no_idle = 0;

		for (int ph = 0; ph < 2; ph++) begin
			write_reg(CFG_MATCH_ID, $urandom);
			write_reg(CFG_SPEED_PER_RPM, $urandom_range(0, 200_000_000));
			write_reg(CFG_INV_TREAD, $urandom);
			drain();
			random_frames(90);
			drain();
		end

		if (fail_count == 0) begin
			$display("** diff_drive_wheel_odometry: PASSED **");
		end else begin
			$display("** diff_drive_wheel_odometry: FAILED **");
		end
		$finish;
	end

endmodule
